FILE: rtl/rida_pkg.sv
// Shared types and constants for the router ID allocator.
`default_nettype none
package rida_pkg;
    localparam int ID_COUNT    = 2048;
    localparam int SHORT_LIMIT = 255;
    localparam int LONG_LIMIT  = 65535;
    localparam int WORD_BITS   = 32;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NO_ID  = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOK,
        S_LOOK_WAIT,
        S_DECIDE,
        S_REQ_RD,
        S_REQ_CHK,
        S_SCAN,
        S_SCAN_CHK,
        S_COMMIT,
        S_FREE_RD,
        S_FREE_WR,
        S_OUT
    } t_state;
endpackage
`default_nettype wire

FILE: rtl/router_id_allocator.sv
// Router ID allocator: free bitmap and owner table in synchronous memories.
//
// Channel  | Dir | Signals                  | Contents (tdata lsb first)
// s_axis   | in  | tvalid tready tdata      | action, node_identity, short_range,
//          |     |                          | has_request, id_value (78 bits in 80)
// m_axis   | out | tvalid tready tdata      | status, assigned_id, allocated_count
//
// One request is handled at a time. Owner lookup walks the table, one entry a
// cycle; the lowest-free search reads and then checks one 32-bit bitmap word at
// a time (up to ID_COUNT/32 words).
// After reset a clearing pass writes every bitmap word with no input accepted.
// The result register holds while m_axis_tready is low; a new request may be
// taken while it waits.
`default_nettype none
module router_id_allocator
    import rida_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // action, node_identity[64], short_range, has_request, id_value[11], zero pad
    input  wire logic [79:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // status[2], assigned_id[11], allocated_count[7], zero pad
    output logic [23:0]      m_axis_tdata
);
    localparam int WORDS = (ID_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int TAW   = $clog2(TABLE_ENTRIES);
    localparam int SHORT_LEN = (SHORT_LIMIT < ID_COUNT) ? SHORT_LIMIT : ID_COUNT;
    localparam int LONG_LEN  = (LONG_LIMIT < ID_COUNT) ? LONG_LIMIT : ID_COUNT;

    // memories
    logic [WORD_BITS-1:0] m_map [WORDS];
    logic [63:0]          m_ident [TABLE_ENTRIES];
    logic [10:0]          m_oid [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_valid;

    logic                 map_we;
    logic [WAW-1:0]       map_wa, map_ra;
    logic [WORD_BITS-1:0] map_wd, r_map_q;
    logic                 tab_we;
    logic [TAW-1:0]       tab_wa, tab_ra;
    logic [63:0]          r_ident_q;
    logic [10:0]          r_oid_q;

    // request and working registers
    t_state r_state, n_state;
    logic        r_act, r_short, r_hreq;
    logic [63:0] r_ident;
    logic [10:0] r_req;
    logic [TAW:0] r_ti;          // lookup index, extra bit for end
    logic [TAW-1:0] r_slot, r_empty;
    logic        r_found, r_has_empty;
    logic [WAW:0] r_wi;          // scan word index
    logic [10:0] r_gid;
    logic [TAW:0] r_cnt;
    logic [1:0]  r_stat;
    logic [WAW:0] r_clr;
    logic        r_clearing;
    logic [23:0] r_out;
    logic        r_ov;

    always_ff @(posedge i_clk) begin
        if (map_we) m_map[map_wa] <= map_wd;
        r_map_q <= m_map[map_ra];
    end
    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            m_ident[tab_wa] <= r_ident;
            m_oid[tab_wa]   <= r_gid;
        end
        r_ident_q <= m_ident[tab_ra];
        r_oid_q   <= m_oid[tab_ra];
    end

    logic [31:0] len;
    assign len = r_short ? 32'(SHORT_LEN) : 32'(LONG_LEN);

    // lowest free bit within the current word, limited by range
    logic [WORD_BITS-1:0] word_m;
    logic [4:0]  fbit;
    logic        fany;
    logic [31:0] wbase;
    always_comb begin
        wbase = 32'(r_wi) * 32'(WORD_BITS);
        for (int b = 0; b < WORD_BITS; b++)
            word_m[b] = r_map_q[b] && ((wbase + 32'(b)) < len);
        fany = |word_m;
        fbit = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
            if (word_m[b]) fbit = 5'(b);
    end

    logic [4:0] req_bit;
    assign req_bit = r_req[4:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:      if (!r_clearing && s_axis_tvalid) n_state = S_LOOK;
            S_LOOK:      n_state = S_LOOK_WAIT;
            S_LOOK_WAIT: if (r_found || r_ti == (TAW+1)'(TABLE_ENTRIES + 1))
                             n_state = S_DECIDE;
            S_DECIDE: begin
                if (r_act) n_state = r_found ? S_FREE_RD : S_OUT;
                else if (!r_found && !r_has_empty) n_state = S_OUT;
                else if (r_hreq && r_found && r_oid_q == r_req) n_state = S_COMMIT;
                else if (r_hreq && 32'(r_req) < len) n_state = S_REQ_RD;
                else n_state = S_SCAN;
            end
            S_REQ_RD:    n_state = S_REQ_CHK;
            S_REQ_CHK:   n_state = r_map_q[req_bit] ? S_COMMIT : S_SCAN;
            S_SCAN:      n_state = S_SCAN_CHK;
            S_SCAN_CHK: begin
                if (fany) n_state = S_COMMIT;
                else if (r_wi == (WAW+1)'(WORDS - 1)
                         || (r_wi + 1'b1) * WORD_BITS >= len) n_state = S_OUT;
                else n_state = S_SCAN;
            end
            S_COMMIT:    n_state = S_OUT;
            S_FREE_RD:   n_state = S_FREE_WR;
            S_FREE_WR:   n_state = S_OUT;
            S_OUT:       if (!r_ov) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // memory control
    always_comb begin
        map_we = 1'b0;
        map_wa = r_req[WAW+4:5];
        map_wd = r_map_q;
        map_ra = r_req[WAW+4:5];
        tab_we = 1'b0;
        tab_wa = r_slot;
        // hold the matched entry on the read port once found
        tab_ra = r_found ? r_slot : r_ti[TAW-1:0];
        if (r_clearing) begin
            map_we = 1'b1;
            map_wa = r_clr[WAW-1:0];
            map_wd = (r_clr == '0) ? {{(WORD_BITS-1){1'b1}}, 1'b0} : '1;
        end
        case (r_state)
            S_SCAN: map_ra = r_wi[WAW-1:0];
            S_SCAN_CHK: begin
                map_ra = r_wi[WAW-1:0] + 1'b1;
                if (fany) begin
                    map_we = 1'b1;
                    map_wa = r_wi[WAW-1:0];
                    map_wd = r_map_q & ~(WORD_BITS'(1) << fbit);
                end
            end
            S_REQ_CHK: if (r_map_q[req_bit]) begin
                map_we = 1'b1;
                map_wd = r_map_q & ~(WORD_BITS'(1) << req_bit);
            end
            S_FREE_WR: if (32'(r_req) < len) begin
                map_we = 1'b1;
                map_wd = r_map_q | (WORD_BITS'(1) << req_bit);
            end
            S_COMMIT: tab_we = 1'b1;
            default: ;
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE) && !r_clearing;

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= '0;
            r_cnt      <= '0;
            r_clr      <= '0;
            r_clearing <= 1'b1;
            r_ov       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_clearing) begin
                r_clr <= r_clr + 1'b1;
                if (r_clr == (WAW+1)'(WORDS - 1)) r_clearing <= 1'b0;
            end
            if (r_ov && m_axis_tready) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: if (s_axis_tvalid && !r_clearing) begin
                    r_act   <= s_axis_tdata[0];
                    r_ident <= s_axis_tdata[64:1];
                    r_short <= s_axis_tdata[65];
                    r_hreq  <= s_axis_tdata[66];
                    r_req   <= s_axis_tdata[77:67];
                    r_ti    <= '0;
                    r_found <= 1'b0;
                    r_has_empty <= 1'b0;
                    r_wi    <= '0;
                    r_gid   <= '0;
                    r_stat  <= ST_OK;
                end
                S_LOOK: r_ti <= r_ti + 1'b1;
                S_LOOK_WAIT: if (!r_found && r_ti != (TAW+1)'(TABLE_ENTRIES + 1)) begin
                    // entry r_ti-1 data is on the read port now
                    if (r_valid[TAW'(r_ti - 1'b1)] && r_ident_q == r_ident) begin
                        r_found <= 1'b1;
                        r_slot  <= TAW'(r_ti - 1'b1);
                    end else begin
                        if (!r_valid[TAW'(r_ti - 1'b1)] && !r_has_empty) begin
                            r_has_empty <= 1'b1;
                            r_empty <= TAW'(r_ti - 1'b1);
                        end
                        r_ti <= r_ti + 1'b1;
                    end
                end
                S_DECIDE: begin
                    if (!r_found) r_slot <= r_empty;
                    if (!r_act && !r_found && !r_has_empty) r_stat <= ST_FULL;
                    if (!r_act && r_hreq && r_found && r_oid_q == r_req) r_gid <= r_req;
                end
                S_REQ_CHK: if (r_map_q[req_bit]) r_gid <= r_req;
                S_SCAN_CHK: begin
                    if (fany) r_gid <= 11'(wbase) | 11'(fbit);
                    else if (r_wi == (WAW+1)'(WORDS - 1)
                             || (r_wi + 1'b1) * WORD_BITS >= len) r_stat <= ST_NO_ID;
                    r_wi <= r_wi + 1'b1;
                end
                S_COMMIT: if (!r_found) begin
                    r_valid[r_slot] <= 1'b1;
                    r_cnt <= r_cnt + 1'b1;
                end
                S_FREE_WR: begin
                    r_valid[r_slot] <= 1'b0;
                    if (r_cnt != '0) r_cnt <= r_cnt - 1'b1;
                end
                S_OUT: if (!r_ov) begin
                    r_ov  <= 1'b1;
                    r_out <= {4'b0, 7'(r_cnt),
                              (r_stat == ST_OK && !r_act) ? r_gid : 11'd0, r_stat};
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_out;
endmodule
`default_nettype wire

FILE: rtl/rida_checker.sv
// Port-level checks for the router ID allocator, bound to the top level.
`default_nettype none
module rida_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata
);
    // hold result while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    // m_axis_tvalid drops after each result transfer
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
        else $error("result repeated after transfer");
    // status code is never 3
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
        else $error("bad status");
    // failure grants no ID
    a_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != 2'd0 |-> m_axis_tdata[12:2] == 11'd0)
        else $error("ID on failure");
endmodule

bind router_id_allocator rida_checker u_rida_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
